// ===== rtl/core/bfd_pkg.sv =====
// bfd_pkg: shared types and constants for the bfd session responder
// used by bfd_ctrl, bfd_dp and bfd_session_responder; no dependencies
`timescale 1ns / 1ps

package bfd_pkg;

    localparam int SESSIONS_DEF = 16;

    localparam logic [19:0] MAX_MS_RST = 20'd1000;
    localparam logic [23:0] MIN_US_RST = 24'd10000;

    // operation codes of the func field
    localparam logic [1:0] FN_PACKET   = 2'd0;
    localparam logic [1:0] FN_TICK     = 2'd1;
    localparam logic [1:0] FN_TRANSMIT = 2'd2;
    localparam logic [1:0] FN_SHUTDOWN = 2'd3;

    // session phases
    localparam logic [1:0] PH_INIT = 2'd0;
    localparam logic [1:0] PH_UP   = 2'd1;
    localparam logic [1:0] PH_DOWN = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // state codes written into packets
    localparam logic [1:0] SC_DOWN = 2'd1;
    localparam logic [1:0] SC_INIT = 2'd2;
    localparam logic [1:0] SC_UP   = 2'd3;

    // register indexes
    localparam logic CFG_MAX_MS = 1'b0;
    localparam logic CFG_MIN_US = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_EVAL,
        ST_FINISH,
        ST_RESULT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_first;
        logic rd;
        logic eval;
        logic finish;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_slot;
        logic prep_done;
    } dp_stat_t;

endpackage

// ===== rtl/core/bfd_ctrl.sv =====
// bfd_ctrl: sequencer that walks the session table once per transaction
// depends on bfd_pkg
`timescale 1ns / 1ps

module bfd_ctrl
    import bfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_PREP;
            ST_PREP:   if (stat.prep_done) state_next = ST_READ;
            ST_READ:   state_next = ST_EVAL;
            ST_EVAL:   state_next = stat.last_slot ? ST_FINISH : ST_READ;
            ST_FINISH: state_next = ST_RESULT;
            ST_RESULT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_PREP:   cmd.scan_first = stat.prep_done;
            ST_READ:   cmd.rd = 1'b1;
            ST_EVAL:   cmd.eval = 1'b1;
            ST_FINISH: cmd.finish = 1'b1;
            ST_RESULT: cmd.emit = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/bfd_dp.sv =====
// bfd_dp: session table memory, slot scan datapath and result register
// depends on bfd_pkg; sequenced by bfd_ctrl
`timescale 1ns / 1ps

module bfd_dp
    import bfd_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [23:0] cfg_data,
    input  logic [1:0]  func,
    input  logic [31:0] peer_addr,
    input  logic [15:0] peer_port,
    input  logic [15:0] listen_port,
    input  logic [7:0]  detect_mult,
    input  logic [31:0] sender_disc,
    input  logic [31:0] your_disc,
    input  logic [31:0] peer_tx_us,
    input  logic [31:0] peer_rx_us,
    output logic        done,
    output logic        sent,
    output logic [31:0] dest_addr,
    output logic [15:0] dest_port,
    output logic [1:0]  state_code,
    output logic [7:0]  mult_out,
    output logic [31:0] my_disc_out,
    output logic [31:0] their_disc_out,
    output logic [31:0] tx_us_out,
    output logic [31:0] rx_us_out,
    output logic        all_closed
);

    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    // session record held in memory, intervals also kept in whole ms
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] tport;
        logic [31:0] their;
        logic [31:0] mine;
        logic [7:0]  mult;
        logic [31:0] tx;
        logic [31:0] rx;
        logic [21:0] tx_ms;
        logic [21:0] rx_ms;
        logic [1:0]  phase;
        logic [31:0] lsent;
        logic [31:0] lrecv;
    } slot_t;

    slot_t mem [SESSIONS];
    logic [SESSIONS-1:0] valid_reg;

    logic [19:0] max_ms_reg;
    logic [23:0] min_us_reg;
    logic [31:0] now_reg;
    logic        closing_reg;

    // latched transaction
    logic [1:0]  fn_reg;
    logic [31:0] addr_reg, sdisc_reg, ydisc_reg, ptx_reg, prx_reg;
    logic [15:0] port_reg, lport_reg;
    logic [7:0]  mult_reg;

    // clamp pipeline
    logic [1:0]  prep_reg;
    logic [35:0] hi_reg;
    logic [31:0] rxc_reg, txc_reg;
    logic [21:0] rxm_reg, txm_reg;

    // scan
    logic [IW-1:0] idx_reg;
    slot_t         rd_reg;
    logic          rdv_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic          best_reg;
    logic [IW-1:0] best_idx_reg;
    logic [31:0]   bw_reg;
    slot_t         best_slot_reg;

    // divider by 1000 through reciprocal: floor(x*274877907 >> 38)
    function automatic logic [21:0] div1000(input logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * 64'd274877907;
        return p[59:38];
    endfunction

    // lower clamp first, then upper clamp
    function automatic logic [31:0] clampv(input logic [31:0] v);
        logic [35:0] r;
        r = {4'd0, v};
        if (r < {12'd0, min_us_reg})
            r = {12'd0, min_us_reg};
        if (r > hi_reg)
            r = hi_reg;
        return r[31:0];
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ms_reg <= MAX_MS_RST;
            min_us_reg <= MIN_US_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CFG_MAX_MS)
                max_ms_reg <= cfg_data[19:0];
            else
                min_us_reg <= cfg_data;
        end
    end

    // transaction latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fn_reg    <= func;
            addr_reg  <= peer_addr;
            port_reg  <= peer_port;
            lport_reg <= listen_port;
            mult_reg  <= detect_mult;
            sdisc_reg <= sender_disc;
            ydisc_reg <= your_disc;
            ptx_reg   <= peer_tx_us;
            prx_reg   <= peer_rx_us;
        end
    end

    // clamp: upper bound product, clamp, then ms conversion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_reg <= '0;
        else if (cmd.load)
            prep_reg <= '0;
        else if (prep_reg != 2'd3)
            prep_reg <= prep_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (prep_reg == 2'd0)
            hi_reg <= {16'd0, max_ms_reg} * 36'd1000;
        if (prep_reg == 2'd1)
        begin
            rxc_reg <= clampv(ptx_reg);
            txc_reg <= clampv(prx_reg);
        end
        if (prep_reg == 2'd2)
        begin
            rxm_reg <= div1000(rxc_reg);
            txm_reg <= div1000(txc_reg);
        end
    end

    assign stat.prep_done = (prep_reg == 2'd3);
    assign stat.last_slot = (idx_reg == IW'(SESSIONS - 1));

    // evaluation terms of the slot just read
    logic [31:0] now_tick;
    logic [31:0] iv, df_sent, w, df_recv;
    logic [39:0] limit;
    logic        key_hit, cand, expire;

    assign now_tick = now_reg + 32'd1;
    assign iv       = {10'd0, rd_reg.tx_ms};
    assign df_sent  = now_reg - rd_reg.lsent;
    assign w        = (rd_reg.phase != PH_UP || df_sent > iv) ? 32'd0 : iv - df_sent;
    assign limit    = {32'd0, rd_reg.mult} * {18'd0, rd_reg.rx_ms};
    assign df_recv  = now_tick - rd_reg.lrecv;
    assign key_hit  = rdv_reg && rd_reg.addr == addr_reg && rd_reg.port == port_reg
                      && rd_reg.their == sdisc_reg;
    assign cand     = rdv_reg && rd_reg.phase != PH_DONE;
    assign expire   = {8'd0, df_recv} > limit || rd_reg.phase == PH_DONE;

    // scan registers and table updates
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_reg  <= mem[idx_reg];
            rdv_reg <= valid_reg[idx_reg];
        end
        if (cmd.scan_first)
        begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            best_reg <= 1'b0;
        end
        if (cmd.eval)
        begin
            idx_reg <= idx_reg + IW'(1);
            case (fn_reg)
                FN_PACKET:
                begin
                    if (key_hit && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (!rdv_reg && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                end
                FN_TRANSMIT:
                begin
                    if (cand && (!best_reg || w < bw_reg))
                    begin
                        best_reg      <= 1'b1;
                        best_idx_reg  <= idx_reg;
                        bw_reg        <= w;
                        best_slot_reg <= rd_reg;
                    end
                end
                default: ;
            endcase
        end
        // table writes
        if (cmd.finish && fn_reg == FN_PACKET)
        begin
            if (hit_reg)
                mem[hit_idx_reg].lrecv <= now_reg;
            else if (free_reg && !closing_reg)
            begin
                mem[free_idx_reg] <= '{addr: addr_reg, port: port_reg, tport: lport_reg,
                    their: sdisc_reg,
                    mine: (ydisc_reg != 32'd0) ? ydisc_reg : sdisc_reg + 32'd1,
                    mult: mult_reg, tx: txc_reg, rx: rxc_reg,
                    tx_ms: txm_reg, rx_ms: rxm_reg, phase: PH_INIT,
                    lsent: now_reg, lrecv: now_reg};
            end
        end
        if (cmd.finish && fn_reg == FN_TRANSMIT && best_reg && bw_reg == 32'd0)
        begin
            mem[best_idx_reg].lsent <= now_reg;
            if (best_slot_reg.phase == PH_INIT)
                mem[best_idx_reg].phase <= PH_UP;
        end
        if (cmd.eval && fn_reg == FN_SHUTDOWN && rdv_reg && rd_reg.phase == PH_UP)
            mem[idx_reg].phase <= PH_DOWN;
    end

    // valid bits, clock, closing flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            now_reg     <= '0;
            closing_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval && fn_reg == FN_TICK && rdv_reg && expire)
                valid_reg[idx_reg] <= 1'b0;
            if (cmd.eval && fn_reg == FN_SHUTDOWN && rdv_reg && rd_reg.phase == PH_INIT)
                valid_reg[idx_reg] <= 1'b0;
            if (cmd.finish && fn_reg == FN_TICK)
                now_reg <= now_tick;
            if (cmd.finish && fn_reg == FN_SHUTDOWN)
                closing_reg <= 1'b1;
            if (cmd.finish && fn_reg == FN_PACKET && !hit_reg && free_reg && !closing_reg)
                valid_reg[free_idx_reg] <= 1'b1;
            if (cmd.finish && fn_reg == FN_TRANSMIT && best_reg && bw_reg == 32'd0
                && best_slot_reg.phase == PH_DOWN)
                valid_reg[best_idx_reg] <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            all_closed     <= closing_reg && (valid_reg == '0);
            sent           <= 1'b0;
            dest_addr      <= '0;
            dest_port      <= '0;
            state_code     <= '0;
            mult_out       <= '0;
            my_disc_out    <= '0;
            their_disc_out <= '0;
            tx_us_out      <= '0;
            rx_us_out      <= '0;
            if (fn_reg == FN_TRANSMIT && best_reg && bw_reg == 32'd0)
            begin
                sent           <= 1'b1;
                dest_addr      <= best_slot_reg.addr;
                dest_port      <= best_slot_reg.tport;
                mult_out       <= best_slot_reg.mult;
                my_disc_out    <= best_slot_reg.mine;
                their_disc_out <= best_slot_reg.their;
                tx_us_out      <= best_slot_reg.tx;
                rx_us_out      <= best_slot_reg.rx;
                case (best_slot_reg.phase)
                    PH_INIT: state_code <= SC_INIT;
                    PH_UP:   state_code <= SC_UP;
                    default: state_code <= SC_DOWN;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/bfd_session_responder.sv =====
// bfd_session_responder: top level, one transaction per start pulse
// sequence from start to the done strobe: the prep steps (upper bound product, clamp,
// ms conversion), a read and an evaluate step per table slot, then finish and result
// a new start is taken only while busy is low, after the last result; the receiver cannot stall
// reset: asynchronous active low; clears session valid bits, clock, closing flag, config
`timescale 1ns / 1ps

module bfd_session_responder
    import bfd_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [23:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] peer_addr,
    input  logic [15:0] peer_port,
    input  logic [15:0] listen_port,
    input  logic [7:0]  detect_mult,
    input  logic [31:0] sender_disc,
    input  logic [31:0] your_disc,
    input  logic [31:0] peer_tx_us,
    input  logic [31:0] peer_rx_us,
    output logic        done,
    output logic        sent,
    output logic [31:0] dest_addr,
    output logic [15:0] dest_port,
    output logic [1:0]  state_code,
    output logic [7:0]  mult_out,
    output logic [31:0] my_disc_out,
    output logic [31:0] their_disc_out,
    output logic [31:0] tx_us_out,
    output logic [31:0] rx_us_out,
    output logic        all_closed
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    bfd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // session table and datapath
    bfd_dp #(.SESSIONS(SESSIONS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .func           (func),
        .peer_addr      (peer_addr),
        .peer_port      (peer_port),
        .listen_port    (listen_port),
        .detect_mult    (detect_mult),
        .sender_disc    (sender_disc),
        .your_disc      (your_disc),
        .peer_tx_us     (peer_tx_us),
        .peer_rx_us     (peer_rx_us),
        .done           (done),
        .sent           (sent),
        .dest_addr      (dest_addr),
        .dest_port      (dest_port),
        .state_code     (state_code),
        .mult_out       (mult_out),
        .my_disc_out    (my_disc_out),
        .their_disc_out (their_disc_out),
        .tx_us_out      (tx_us_out),
        .rx_us_out      (rx_us_out),
        .all_closed     (all_closed)
    );

endmodule

// ===== test/bfd_session_responder_tb.sv =====
// bfd_session_responder_tb: self-checking testbench for the bfd session responder
// drives packet, tick, transmit and shutdown transactions and checks every result against
// an in-bench session table model; depends on bfd_pkg and bfd_session_responder
`timescale 1ns / 1ps

module bfd_session_responder_tb;
    import bfd_pkg::*;

    localparam int NSESS = 16;
    localparam int POOL_KEYS = 24;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [15:0] listen_port;
        logic [7:0]  detect_mult;
        logic [31:0] sender_disc;
        logic [31:0] your_disc;
        logic [31:0] peer_tx_us;
        logic [31:0] peer_rx_us;
    } bfd_txn_t;

    typedef struct {
        logic        sent;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [1:0]  state_code;
        logic [7:0]  mult_out;
        logic [31:0] my_disc;
        logic [31:0] their_disc;
        logic [31:0] tx_us;
        logic [31:0] rx_us;
        logic        all_closed;
    } bfd_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [23:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = FN_TICK;
    logic [31:0] peer_addr = '0;
    logic [15:0] peer_port = '0;
    logic [15:0] listen_port = '0;
    logic [7:0]  detect_mult = '0;
    logic [31:0] sender_disc = '0;
    logic [31:0] your_disc = '0;
    logic [31:0] peer_tx_us = '0;
    logic [31:0] peer_rx_us = '0;
    logic        done;
    logic        sent;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [1:0]  state_code;
    logic [7:0]  mult_out;
    logic [31:0] my_disc_out;
    logic [31:0] their_disc_out;
    logic [31:0] tx_us_out;
    logic [31:0] rx_us_out;
    logic        all_closed;

    bfd_session_responder u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .start(start), .busy(busy), .func(func), .peer_addr(peer_addr),
        .peer_port(peer_port), .listen_port(listen_port), .detect_mult(detect_mult),
        .sender_disc(sender_disc), .your_disc(your_disc), .peer_tx_us(peer_tx_us),
        .peer_rx_us(peer_rx_us), .done(done), .sent(sent), .dest_addr(dest_addr),
        .dest_port(dest_port), .state_code(state_code), .mult_out(mult_out),
        .my_disc_out(my_disc_out), .their_disc_out(their_disc_out),
        .tx_us_out(tx_us_out), .rx_us_out(rx_us_out), .all_closed(all_closed)
    );

    always #1 clk = ~clk;

    // session table model
    logic [19:0] m_max_ms;
    logic [23:0] m_min_us;
    logic        s_valid [NSESS];
    logic [31:0] s_addr [NSESS];
    logic [15:0] s_port [NSESS];
    logic [15:0] s_target [NSESS];
    logic [31:0] s_their [NSESS];
    logic [31:0] s_mine [NSESS];
    logic [7:0]  s_mult [NSESS];
    logic [31:0] s_tx [NSESS];
    logic [31:0] s_rx [NSESS];
    logic [1:0]  s_phase [NSESS];
    logic [31:0] s_last_sent [NSESS];
    logic [31:0] s_last_recv [NSESS];
    logic [31:0] now_ms;
    logic        shutting;

    bfd_txn_t   pending_q [$];
    bfd_reply_t reply_q [$];
    bfd_txn_t   cur_txn;
    int         errors = 0;
    int         n_in = 0;
    int         n_out = 0;
    int         n_sent = 0;
    int         idle_cycles = 0;

    // key pool so packets hit known sessions often
    logic [31:0] key_addr [POOL_KEYS];
    logic [15:0] key_port [POOL_KEYS];
    logic [31:0] key_disc [POOL_KEYS];

    function automatic logic [31:0] clamp_us(logic [31:0] v);
        logic [63:0] hi;
        logic [63:0] r;
        hi = 64'(m_max_ms) * 64'd1000;
        r = 64'(v);
        if (r < 64'(m_min_us))
            r = 64'(m_min_us);
        if (r > hi)
            r = hi;
        return r[31:0];
    endfunction

    function automatic logic [31:0] slot_wait(int i);
        logic [31:0] iv;
        logic [31:0] df;
        if (s_phase[i] != PH_UP)
            return 32'd0;
        iv = s_tx[i] / 32'd1000;
        df = now_ms - s_last_sent[i];
        if (df > iv)
            return 32'd0;
        return iv - df;
    endfunction

    // advance the table model by one transaction and return the expected reply
    function automatic bfd_reply_t respond(bfd_txn_t t);
        bfd_reply_t r;
        int i;
        int freeslot;
        int best;
        logic hit;
        logic any;
        logic [31:0] w;
        logic [31:0] bw;
        logic [63:0] lim;
        logic [31:0] df;
        r = '{default: '0};
        freeslot = -1;
        best = -1;
        bw = '0;
        hit = 1'b0;
        any = 1'b0;
        case (t.func)
            FN_PACKET: begin
                for (i = 0; i < NSESS; i++) begin
                    if (s_valid[i]) begin
                        if (!hit && s_addr[i] == t.peer_addr && s_port[i] == t.peer_port
                            && s_their[i] == t.sender_disc) begin
                            s_last_recv[i] = now_ms;
                            hit = 1'b1;
                        end
                    end else if (freeslot < 0) begin
                        freeslot = i;
                    end
                end
                if (!hit && !shutting && freeslot >= 0) begin
                    i = freeslot;
                    s_valid[i] = 1'b1;
                    s_addr[i] = t.peer_addr;
                    s_port[i] = t.peer_port;
                    s_target[i] = t.listen_port;
                    s_mult[i] = t.detect_mult;
                    s_their[i] = t.sender_disc;
                    s_mine[i] = (t.your_disc != 0) ? t.your_disc : t.sender_disc + 32'd1;
                    s_rx[i] = clamp_us(t.peer_tx_us);
                    s_tx[i] = clamp_us(t.peer_rx_us);
                    s_phase[i] = PH_INIT;
                    s_last_sent[i] = now_ms;
                    s_last_recv[i] = now_ms;
                end
            end
            FN_TICK: begin
                now_ms = now_ms + 32'd1;
                for (i = 0; i < NSESS; i++) begin
                    if (s_valid[i]) begin
                        df = now_ms - s_last_recv[i];
                        lim = 64'(s_mult[i]) * 64'(s_rx[i] / 32'd1000);
                        if (64'(df) > lim || s_phase[i] == PH_DONE)
                            s_valid[i] = 1'b0;
                    end
                end
            end
            FN_TRANSMIT: begin
                for (i = 0; i < NSESS; i++) begin
                    if (s_valid[i] && s_phase[i] != PH_DONE) begin
                        w = slot_wait(i);
                        if (best < 0 || w < bw) begin
                            best = i;
                            bw = w;
                        end
                    end
                end
                if (best >= 0 && bw == 0) begin
                    i = best;
                    r.sent = 1'b1;
                    r.dest_addr = s_addr[i];
                    r.dest_port = s_target[i];
                    r.mult_out = s_mult[i];
                    r.my_disc = s_mine[i];
                    r.their_disc = s_their[i];
                    r.tx_us = s_tx[i];
                    r.rx_us = s_rx[i];
                    s_last_sent[i] = now_ms;
                    if (s_phase[i] == PH_INIT) begin
                        r.state_code = SC_INIT;
                        s_phase[i] = PH_UP;
                    end else if (s_phase[i] == PH_UP) begin
                        r.state_code = SC_UP;
                    end else begin
                        r.state_code = SC_DOWN;
                        s_valid[i] = 1'b0;
                    end
                end
            end
            default: begin
                shutting = 1'b1;
                for (i = 0; i < NSESS; i++) begin
                    if (s_valid[i]) begin
                        if (s_phase[i] == PH_UP)
                            s_phase[i] = PH_DOWN;
                        else if (s_phase[i] == PH_INIT)
                            s_valid[i] = 1'b0;
                    end
                end
            end
        endcase
        for (i = 0; i < NSESS; i++)
            any = any | s_valid[i];
        r.all_closed = shutting && !any;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on reply %0d: %s got %h expected %h", n_out, what, got, want);
    endtask

    // driver: hands queued transactions to the block, idling at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                reply_q.push_back(respond(cur_txn));
                n_in++;
            end
            if (!start || !busy) begin
                if (pending_q.size() > 0 &&
                    ((n_in >= 600 && n_in < 800) || $urandom_range(99) >= 37)) begin
                    cur_txn = pending_q.pop_front();
                    func <= cur_txn.func;
                    peer_addr <= cur_txn.peer_addr;
                    peer_port <= cur_txn.peer_port;
                    listen_port <= cur_txn.listen_port;
                    detect_mult <= cur_txn.detect_mult;
                    sender_disc <= cur_txn.sender_disc;
                    your_disc <= cur_txn.your_disc;
                    peer_tx_us <= cur_txn.peer_tx_us;
                    peer_rx_us <= cur_txn.peer_rx_us;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each reply with the oldest expectation
    always @(posedge clk) begin
        bfd_reply_t e;
        if (rst_n && done) begin
            if (reply_q.size() == 0) begin
                report("unexpected reply", 32'(done), 32'd0);
            end else begin
                e = reply_q.pop_front();
                if (sent !== e.sent) report("sent", 32'(sent), 32'(e.sent));
                if (dest_addr !== e.dest_addr) report("dest_addr", dest_addr, e.dest_addr);
                if (dest_port !== e.dest_port)
                    report("dest_port", 32'(dest_port), 32'(e.dest_port));
                if (state_code !== e.state_code)
                    report("state_code", 32'(state_code), 32'(e.state_code));
                if (mult_out !== e.mult_out)
                    report("mult_out", 32'(mult_out), 32'(e.mult_out));
                if (my_disc_out !== e.my_disc) report("my_disc_out", my_disc_out, e.my_disc);
                if (their_disc_out !== e.their_disc)
                    report("their_disc_out", their_disc_out, e.their_disc);
                if (tx_us_out !== e.tx_us) report("tx_us_out", tx_us_out, e.tx_us);
                if (rx_us_out !== e.rx_us) report("rx_us_out", rx_us_out, e.rx_us);
                if (all_closed !== e.all_closed)
                    report("all_closed", 32'(all_closed), 32'(e.all_closed));
                if (e.sent) n_sent++;
            end
            n_out++;
        end
    end

    // watchdog on cycles with no transaction moving
    always @(posedge clk) begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled after %0d transactions and %0d replies", n_in, n_out);
            $display("bfd_session_responder_tb failed");
            $finish;
        end
    end

    function automatic bfd_txn_t mk(logic [1:0] f, logic [31:0] a, logic [15:0] p,
                                    logic [15:0] lp, logic [7:0] m, logic [31:0] sd,
                                    logic [31:0] yd, logic [31:0] tx, logic [31:0] rx);
        bfd_txn_t t;
        t.func = f; t.peer_addr = a; t.peer_port = p; t.listen_port = lp;
        t.detect_mult = m; t.sender_disc = sd; t.your_disc = yd;
        t.peer_tx_us = tx; t.peer_rx_us = rx;
        return t;
    endfunction

    function automatic logic [31:0] rand_interval();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(60000);
            default: return $urandom_range(30000, 1);
        endcase
    endfunction

    // mostly well-formed traffic on pooled keys, some fully random noise
    function automatic bfd_txn_t rand_txn(int shut_pct);
        bfd_txn_t t;
        int k;
        int roll;
        t = mk(FN_TICK, $urandom, 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
               $urandom, $urandom, $urandom);
        roll = $urandom_range(99);
        k = $urandom_range(POOL_KEYS - 1);
        if (roll < shut_pct) begin
            t.func = FN_SHUTDOWN;
        end else if (roll < 36) begin
            t.func = FN_PACKET;
            t.peer_addr = key_addr[k];
            t.peer_port = key_port[k];
            t.sender_disc = key_disc[k];
            t.detect_mult = 8'($urandom_range(6));
            if ($urandom_range(1) == 0) t.your_disc = '0;
            t.peer_tx_us = rand_interval();
            t.peer_rx_us = rand_interval();
        end else if (roll < 44) begin
            t.func = FN_PACKET;
        end else if (roll < 72) begin
            t.func = FN_TICK;
        end else begin
            t.func = FN_TRANSMIT;
        end
        return t;
    endfunction

    task automatic drain();
        while (pending_q.size() > 0 || start || reply_q.size() > 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        if (idx == CFG_MAX_MS) m_max_ms = v[19:0];
        else m_min_us = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count, int shut_pct);
        int n;
        for (n = 0; n < count; n++)
            pending_q.push_back(rand_txn(shut_pct));
        drain();
    endtask

    // stimulus
    initial begin
        int i;
        m_max_ms = MAX_MS_RST;
        m_min_us = MIN_US_RST;
        now_ms = '0;
        shutting = 1'b0;
        for (i = 0; i < NSESS; i++) begin
            s_valid[i] = 1'b0;
            s_phase[i] = PH_INIT;
        end
        for (i = 0; i < POOL_KEYS; i++) begin
            key_addr[i] = $urandom;
            key_port[i] = 16'($urandom);
            key_disc[i] = $urandom;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: field extremes, zero discriminator wrap, due and not due, refresh
        pending_q.push_back(mk(FN_TRANSMIT, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_q.push_back(mk(FN_PACKET, '0, '0, '0, 8'd3, 32'hffff_ffff, '0, '0, '0));
        pending_q.push_back(mk(FN_PACKET, '1, '1, '1, 8'hff, '0, '1, '1, '1));
        pending_q.push_back(mk(FN_PACKET, 32'h0a00_0001, 16'd3784, 16'd3784, 8'd1,
                               32'h1234, 32'h0, 32'd25000, 32'd50));
        pending_q.push_back(mk(FN_TRANSMIT, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_q.push_back(mk(FN_TRANSMIT, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_q.push_back(mk(FN_TRANSMIT, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_q.push_back(mk(FN_TRANSMIT, '0, '0, '0, '0, '0, '0, '0, '0));
        for (i = 0; i < 12; i++)
            pending_q.push_back(mk(FN_TICK, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_q.push_back(mk(FN_PACKET, 32'h0a00_0001, 16'd3784, 16'd1, 8'd9,
                               32'h1234, 32'h5, 32'd1, 32'd1));
        pending_q.push_back(mk(FN_TRANSMIT, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_q.push_back(mk(FN_TRANSMIT, '0, '0, '0, '0, '0, '0, '0, '0));
        drain();

        // tight clamps, fast aging
        write_reg(CFG_MAX_MS, 24'd10);
        write_reg(CFG_MIN_US, 24'd1);
        random_phase(350, 0);

        // widest clamps, sessions live long so the table fills
        write_reg(CFG_MAX_MS, 24'd1000000);
        write_reg(CFG_MIN_US, 24'd10000000);
        random_phase(250, 0);

        // crossed clamps, upper one wins
        write_reg(CFG_MAX_MS, 24'd10);
        random_phase(300, 0);

        write_reg(CFG_MAX_MS, 24'd20);
        write_reg(CFG_MIN_US, 24'd5000);
        random_phase(430, 0);

        // shutdown: down packets, packets while closing, repeated shutdowns
        for (i = 0; i < 8; i++)
            pending_q.push_back(rand_txn(0));
        pending_q.push_back(mk(FN_SHUTDOWN, '0, '0, '0, '0, '0, '0, '0, '0));
        random_phase(100, 4);

        $display("covered %0d transactions and %0d replies, %0d with a packet sent",
                 n_in, n_out, n_sent);
        if (errors == 0)
            $display("bfd_session_responder_tb passed");
        else
            $display("bfd_session_responder_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bfd_pkg.sv
rtl/core/bfd_ctrl.sv
rtl/core/bfd_dp.sv
rtl/core/bfd_session_responder.sv
test/bfd_session_responder_tb.sv
